// ===== hdl/fptt_pkg.sv =====
package fptt_pkg;

    // Fixed field widths of the stream items
    localparam int INDEX_W     = 7;
    localparam int TERM_W      = 31;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    // First index that takes an addition
    localparam logic [INDEX_W-1:0] FIRST_STEP = INDEX_W'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIB,
        ST_TEST,
        ST_DIV,
        ST_FIN
    } fsm_t;

    // Status of the remainder unit towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } rem_stat_t;

endpackage

// ===== hdl/fptt_rem.sv =====
module fptt_rem
    import fptt_pkg::*;
#(
    parameter int W = 31
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] remainder,
    output rem_stat_t    stat
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
            rem_next  = '0;
            dvd_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = diff[W] ? trial[W-1:0] : diff[W-1:0];
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/fibonacci_term_primality_test_core.sv =====
// Operation: the term is built by repeated addition up to idx, then each trial divisor
// takes a start state, the bit-serial remainder steps and a result state; the largest
// prime term in range (index 45) takes some 20 800 trials.
// One item at a time; the bit-serial remainder unit dominates the run time.
// A finished result waits in an output register while the next item is taken.
// Reset (rst_n low, asynchronous) empties the sequencer and the output register.
module fibonacci_term_primality_test_core
    import fptt_pkg::*;
#(
    parameter int MAX_INDEX  = 47,
    parameter int VALUE_BITS = 31
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [6:0] term_index, [7] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [30:0] term_value, [31] prime_flag,
                                              // [62:32] lowest_divisor, [63] range_error
);

    localparam int VB = VALUE_BITS;

    // ---------------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------------
    fsm_t               state_reg, state_next;
    logic               out_valid_reg, out_valid_next;

    logic [INDEX_W-1:0] idx_reg, idx_next;       // requested index
    logic [INDEX_W-1:0] step_reg, step_next;     // index of the next addition
    logic [VB-1:0]      lo_reg, lo_next;         // older term of the pair
    logic [VB-1:0]      hi_reg, hi_next;         // newer term of the pair
    logic [VB-1:0]      term_reg, term_next;     // term under test
    logic               ovf_reg, ovf_next;       // term no longer fits VB bits
    logic [VB-1:0]      d_reg, d_next;           // trial divisor
    logic [VB:0]        sq_reg, sq_next;         // trial divisor squared

    // Result waiting for the output register
    logic               res_prime_reg, res_prime_next;
    logic [VB-1:0]      res_div_reg, res_div_next;
    logic               res_err_reg, res_err_next;

    // Output register
    logic [TERM_W-1:0]  out_term_reg, out_term_next;
    logic               out_prime_reg, out_prime_next;
    logic [TERM_W-1:0]  out_div_reg, out_div_next;
    logic               out_err_reg, out_err_next;

    // Shared adder: Fibonacci step, and square update (d+1)^2 = d^2 + 2d + 1
    logic [VB:0]        add_a, add_b, add_sum;

    // Remainder unit
    logic               rem_start;
    logic [VB-1:0]      rem_value;
    rem_stat_t          rem_stat;

    assign add_sum = add_a + add_b;

    fptt_rem #(
        .W (VB)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (term_reg),
        .divisor   (d_reg),
        .remainder (rem_value),
        .stat      (rem_stat)
    );

    // ---------------------------------------------------------------------
    // Next state and datapath control
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        term_next      = term_reg;
        ovf_next       = ovf_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        res_prime_next = res_prime_reg;
        res_div_next   = res_div_reg;
        res_err_next   = res_err_reg;
        out_term_next  = out_term_reg;
        out_prime_next = out_prime_reg;
        out_div_next   = out_div_reg;
        out_err_next   = out_err_reg;
        add_a          = {1'b0, lo_reg};
        add_b          = {1'b0, hi_reg};
        rem_start      = 1'b0;
        s_tready       = 1'b0;

        // Drop the result once the sink has taken it
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    idx_next      = s_tdata[INDEX_W-1:0];
                    step_next     = FIRST_STEP;
                    lo_next       = '0;
                    hi_next       = VB'(1);
                    term_next     = '0;
                    ovf_next      = 1'b0;
                    res_prime_next = 1'b0;
                    res_div_next  = '0;
                    res_err_next  = 1'b0;
                    if (s_tdata[INDEX_W-1:0] > INDEX_W'(MAX_INDEX))
                    begin
                        res_err_next = 1'b1;
                        state_next   = ST_FIN;
                    end
                    else
                        state_next = ST_FIB;
                end
            end

            ST_FIB:
            begin
                if (step_reg <= idx_reg)
                begin
                    // Advance the pair by one addition
                    term_next = add_sum[VB-1:0];
                    ovf_next  = ovf_reg | add_sum[VB];
                    lo_next   = hi_reg;
                    hi_next   = add_sum[VB-1:0];
                    step_next = step_reg + INDEX_W'(1);
                end
                else
                begin
                    priority if (ovf_reg)
                    begin
                        res_err_next = 1'b1;
                        state_next   = ST_FIN;
                    end
                    else if (term_reg == '0)
                        state_next = ST_FIN;
                    else if (term_reg == VB'(1))
                    begin
                        res_prime_next = 1'b1;
                        state_next     = ST_FIN;
                    end
                    else
                    begin
                        d_next     = VB'(2);
                        sq_next    = (VB+1)'(4);
                        state_next = ST_TEST;
                    end
                end
            end

            ST_TEST:
            begin
                if (sq_reg > {1'b0, term_reg})
                begin
                    // No divisor up to the square root: prime
                    res_prime_next = 1'b1;
                    res_div_next   = term_reg;
                    state_next     = ST_FIN;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                add_a = sq_reg;
                add_b = {d_reg, 1'b1};
                if (rem_stat.done)
                begin
                    if (rem_value == '0)
                    begin
                        res_div_next = d_reg;
                        state_next   = ST_FIN;
                    end
                    else
                    begin
                        sq_next    = add_sum;
                        d_next     = d_reg + VB'(1);
                        state_next = ST_TEST;
                    end
                end
            end

            ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_term_next  = res_err_reg ? '0 : TERM_W'(term_reg);
                    out_prime_next = res_prime_reg;
                    out_div_next   = TERM_W'(res_div_reg);
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        term_reg      <= term_next;
        ovf_reg       <= ovf_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        res_prime_reg <= res_prime_next;
        res_div_reg   <= res_div_next;
        res_err_reg   <= res_err_next;
        out_term_reg  <= out_term_next;
        out_prime_reg <= out_prime_next;
        out_div_reg   <= out_div_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_err_reg, out_div_reg, out_prime_reg, out_term_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_err_reg) |-> (out_term_reg == '0 && !out_prime_reg
                                       && out_div_reg == '0))
        else $error("range error result carries a term or divisor");

    a_prime_div: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_prime_reg && out_term_reg > TERM_W'(1))
            |-> (out_div_reg == out_term_reg))
        else $error("prime term above one without itself as divisor");

    a_rem_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.done |-> (state_reg == ST_DIV))
        else $error("remainder finished outside the division phase");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        rem_start |-> (!rem_stat.busy && !rem_stat.done))
        else $error("remainder unit started while still working");

endmodule

// ===== dv/fibonacci_term_primality_test_core_test.sv =====
`timescale 1ns / 1ps

import fptt_pkg::*;

// One result item as it travels on m_tdata, lowest field last
typedef struct packed {
    logic              range_error;
    logic [TERM_W-1:0] lowest_divisor;
    logic              prime_flag;
    logic [TERM_W-1:0] term_value;
} fib_verdict_t;

class fib_scoreboard;
    localparam int LAST_INDEX = 47;
    localparam int TERM_BITS  = 31;

    fib_verdict_t awaited[$];
    int           failures;

    function new();
        failures = 0;
    endfunction

    // Build the term by repeated addition, then trial-divide it
    function fib_verdict_t predict(logic [INDEX_W-1:0] idx);
        fib_verdict_t    v;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned term;
        longint unsigned d;
        bit              found;
        v = '0;
        lo = 0;
        hi = 1;
        term = 0;
        found = 1'b0;
        if (idx > LAST_INDEX) begin
            v.range_error = 1'b1;
            return v;
        end
        for (int unsigned i = FIRST_STEP; i <= idx; i++) begin
            term = lo + hi;
            lo = hi;
            hi = term;
        end
        if (term > ((64'd1 << TERM_BITS) - 1)) begin
            v.range_error = 1'b1;
            return v;
        end
        v.term_value = TERM_W'(term);
        if (term == 0) begin
            return v;
        end
        if (term == 1) begin
            v.prime_flag = 1'b1;
            return v;
        end
        for (d = 2; d * d <= term && !found; d++) begin
            if (term % d == 0) begin
                found = 1'b1;
                v.lowest_divisor = TERM_W'(d);
            end
        end
        if (!found) begin
            v.prime_flag = 1'b1;
            v.lowest_divisor = TERM_W'(term);
        end
        return v;
    endfunction

    function void note_term(logic [INDEX_W-1:0] idx);
        awaited.push_back(predict(idx));
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
        fib_verdict_t got;
        fib_verdict_t want;
        got = data;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, data);
            failures++;
            return;
        end
        want = awaited.pop_front();
        if (got.term_value !== want.term_value) begin
            $display("%0t: term_value expected %0d, got %0d",
                     $time, want.term_value, got.term_value);
            failures++;
        end
        if (got.prime_flag !== want.prime_flag) begin
            $display("%0t: prime_flag expected %0b, got %0b",
                     $time, want.prime_flag, got.prime_flag);
            failures++;
        end
        if (got.lowest_divisor !== want.lowest_divisor) begin
            $display("%0t: lowest_divisor expected %0d, got %0d",
                     $time, want.lowest_divisor, got.lowest_divisor);
            failures++;
        end
        if (got.range_error !== want.range_error) begin
            $display("%0t: range_error expected %0b, got %0b",
                     $time, want.range_error, got.range_error);
            failures++;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module fibonacci_term_primality_test_core_test;

    // A single prime term near the top of the range runs long with no handshake at all,
    // so STALL_LIMIT leaves ample room for that before giving up.
    localparam int STALL_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 200;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [6:0] term_index, [7] zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [30:0] term_value, [31] prime_flag,
                                            // [62:32] lowest_divisor, [63] range_error

    fib_scoreboard board = new();

    // Idle and stall odds out of a hundred, set per phase by the main sequence
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Cycles for which the receiver is to hold m_tready low regardless of odds
    int hold_left = 0;

    // Opening items: the small-index zeros, the one and the two, small primes and
    // composites, the last index that fits, out-of-range indices with every
    // upper bit, and the indices that the random picks leave out.
    int opening_terms[23] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 13, 14, 24, 45, 47,
                              48, 64, 100, 127, 30, 32, 35, 42, 44};

    fibonacci_term_primality_test_core #(
        .MAX_INDEX  (47),
        .VALUE_BITS (31)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Offer one item, idling first at the phase's odds, and hold it until taken.
    // tvalid is only lowered on an idle cycle, so back-to-back items keep it high.
    task automatic send_term(input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(idx);
        do
            @(posedge clk);
        while (!s_tready);
        board.note_term(idx);
    endtask

    // Drop tvalid and wait until every awaited result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly in-range indices with random content; some out-of-range and edge
    // picks. Indices 30, 32, 35, 42 and 44 are left to the opening items.
    function automatic logic [INDEX_W-1:0] pick_index();
        int sel;
        int v;
        int edge_picks[9] = '{0, 1, 2, 3, 4, 5, 47, 48, 127};
        sel = $urandom_range(99);
        if (sel < 20)
            return INDEX_W'($urandom_range(127, 48));
        if (sel < 30)
            return INDEX_W'(edge_picks[$urandom_range(8)]);
        do
            v = $urandom_range(47);
        while (v == 30 || v == 32 || v == 35 || v == 42 || v == 44);
        return INDEX_W'(v);
    endfunction

    // Receiver: check each item taken at this edge, then choose the next tready
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: count edges with no handshake on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening items at full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (opening_terms[k])
            send_term(INDEX_W'(opening_terms[k]));
        wait_drained();

        // Hold the receiver off while cheap items keep coming, so that the
        // output register fills and the block pushes back on its input
        hold_left = 3000;
        for (int k = 0; k < 6; k++)
            send_term(INDEX_W'(10 + k));
        wait_drained();

        // Random items in four idling phases, draining between them
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int k = 0; k < 18; k++)
                send_term(pick_index());
            wait_drained();
        end

        // Let any stray result surface before the verdict
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
